// ===== hw/rtl/bsdf_pkg.sv =====
// Shared types, constants and helper functions for the box distance merge core.
// No dependencies; used by every module in hw/rtl.
package bsdf_pkg;

  // Distance word width and largest representable distance
  localparam int DIST_W = 32;
  localparam int HALF_W = 31;
  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;
  localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;

  // Number of root digits, one pipeline stage each
  localparam int SQRT_STEPS = RAD_W / 2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_Z   = 3'd5;

  // Per-item sideband carried alongside the radicand through the root pipeline
  typedef struct packed {
    logic signed [DIST_W-1:0] cur;      // stored distance
    logic signed [DIST_W-1:0] qmax;     // largest excess, valid when inside
    logic                     outside;  // some excess is positive
    logic                     too_big;  // some excess is 2^31 or more
  } side_t;

  // Working pair of the digit-by-digit root
  typedef struct packed {
    logic [RAD_W-1:0] rem;
    logic [RAD_W-1:0] root;
  } sqrt_t;

  // One digit of the integer square root
  function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [RAD_W-1:0] bitv);
    logic [RAD_W-1:0] trial;
    sqrt_t            o;
    trial = s.root + bitv;
    if (s.rem >= trial) begin
      o.rem  = s.rem - trial;
      o.root = (s.root >> 1) + bitv;
    end else begin
      o.rem  = s.rem;
      o.root = s.root >> 1;
    end
    return o;
  endfunction

endpackage

// ===== hw/rtl/bsdf_front.sv =====
// Front pipeline: per-axis excess, clipping, squaring and sum of squares.
// Five register stages; depends on bsdf_pkg.
module bsdf_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [bsdf_pkg::DIST_W-1:0]   pos_x,
  input  logic signed [bsdf_pkg::DIST_W-1:0]   pos_y,
  input  logic signed [bsdf_pkg::DIST_W-1:0]   pos_z,
  input  logic signed [bsdf_pkg::DIST_W-1:0]   current_distance,
  input  logic signed [bsdf_pkg::DIST_W-1:0]   center_x,
  input  logic signed [bsdf_pkg::DIST_W-1:0]   center_y,
  input  logic signed [bsdf_pkg::DIST_W-1:0]   center_z,
  input  logic        [bsdf_pkg::HALF_W-1:0]   half_extent_x,
  input  logic        [bsdf_pkg::HALF_W-1:0]   half_extent_y,
  input  logic        [bsdf_pkg::HALF_W-1:0]   half_extent_z,
  output logic                                 out_valid,
  output logic        [bsdf_pkg::RAD_W-1:0]    out_sum,
  output bsdf_pkg::side_t                      out_side
);

  localparam int DW = bsdf_pkg::DIST_W + 1;   // difference width
  localparam int QW = bsdf_pkg::DIST_W + 2;   // excess width
  localparam int HW = bsdf_pkg::HALF_W;
  localparam int SW = 2 * HW;                 // square width

  logic [4:0] v;

  // Stage 1: differences
  logic signed [DW-1:0] d1 [3];
  logic signed [bsdf_pkg::DIST_W-1:0] cur1, cur2, cur3;

  // Stage 2: excesses
  logic signed [QW-1:0] q2 [3];
  logic signed [QW-1:0] ad2 [3];
  logic signed [QW-1:0] q2_next [3];

  // Stage 3: clipped excesses and flags
  logic [HW-1:0] qc3 [3];
  logic [HW-1:0] qc3_next [3];
  logic signed [bsdf_pkg::DIST_W-1:0] qmax3;
  logic outside3, big3;
  logic [2:0] pos_ax, big_ax;
  logic signed [QW-1:0] m01, m012;

  // Stage 4: squares
  logic [SW-1:0] sq4 [3];
  bsdf_pkg::side_t side4, side5;

  // Stage 5: sum
  logic [bsdf_pkg::RAD_W-1:0] sum5;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:0], in_valid};
    end
  end

  // Stage 1: p - c, exact on 33 bits
  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= DW'(pos_x) - DW'(center_x);
      d1[1] <= DW'(pos_y) - DW'(center_y);
      d1[2] <= DW'(pos_z) - DW'(center_z);
      cur1  <= current_distance;
    end
  end

  // Stage 2: |d| - h, exact on 34 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ad2[i] = d1[i][DW-1] ? -QW'(d1[i]) : QW'(d1[i]);
    end
    q2_next[0] = ad2[0] - $signed({3'b000, half_extent_x});
    q2_next[1] = ad2[1] - $signed({3'b000, half_extent_y});
    q2_next[2] = ad2[2] - $signed({3'b000, half_extent_z});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        q2[i] <= q2_next[i];
      end
      cur2 <= cur1;
    end
  end

  // Stage 3: classify each axis, clip, and find the largest excess
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_ax[i]   = !q2[i][QW-1] && (q2[i] != '0);
      big_ax[i]   = !q2[i][QW-1] && (q2[i][QW-2:HW] != '0);
      qc3_next[i] = (pos_ax[i] && !big_ax[i]) ? q2[i][HW-1:0] : '0;
    end
    m01  = (q2[0] > q2[1]) ? q2[0] : q2[1];
    m012 = (m01 > q2[2]) ? m01 : q2[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        qc3[i] <= qc3_next[i];
      end
      qmax3    <= m012[bsdf_pkg::DIST_W-1:0];
      outside3 <= |pos_ax;
      big3     <= |big_ax;
      cur3     <= cur2;
    end
  end

  // Stage 4: square each clipped excess
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= qc3[i] * qc3[i];
      end
      side4.cur     <= cur3;
      side4.qmax    <= qmax3;
      side4.outside <= outside3;
      side4.too_big <= big3;
    end
  end

  // Stage 5: sum of squares, fits in 64 bits
  always_ff @(posedge clk) begin
    if (en) begin
      sum5  <= bsdf_pkg::RAD_W'(sq4[0]) + bsdf_pkg::RAD_W'(sq4[1])
             + bsdf_pkg::RAD_W'(sq4[2]);
      side5 <= side4;
    end
  end

  assign out_valid = v[4];
  assign out_sum   = sum5;
  assign out_side  = side5;

endmodule

// ===== hw/rtl/bsdf_sqrt_pipe.sv =====
// Pipelined integer square root, one root digit per register stage.
// Carries the per-item sideband along; depends on bsdf_pkg.
module bsdf_sqrt_pipe (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [bsdf_pkg::RAD_W-1:0]        in_rad,
  input  bsdf_pkg::side_t                   in_side,
  output logic                              out_valid,
  output logic [bsdf_pkg::ROOT_W-1:0]       out_root,
  output bsdf_pkg::side_t                   out_side
);

  localparam int N = bsdf_pkg::SQRT_STEPS;

  logic            v    [N+1];
  bsdf_pkg::sqrt_t st   [N+1];
  bsdf_pkg::side_t side [N+1];

  assign v[0]         = in_valid;
  assign st[0].rem    = in_rad;
  assign st[0].root   = '0;
  assign side[0]      = in_side;

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [bsdf_pkg::RAD_W-1:0] Bit =
      bsdf_pkg::RAD_W'(1) << (bsdf_pkg::RAD_W - 2 - 2 * k);

    // Advance one digit per stage
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1]   <= bsdf_pkg::sqrt_step(st[k], Bit);
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = v[N];
  assign out_root  = st[N].root[bsdf_pkg::ROOT_W-1:0];
  assign out_side  = side[N];

endmodule

// ===== hw/rtl/bsdf_out_buf.sv =====
// Output register with skid entry; stalls the pipeline only when both are full.
// Depends on bsdf_pkg.
module bsdf_out_buf (
  input  logic                                clk,
  input  logic                                rst,
  output logic                                en,
  input  logic                                in_valid,
  input  logic signed [bsdf_pkg::DIST_W-1:0]  in_data,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic        [bsdf_pkg::DIST_W-1:0]  m_tdata
);

  logic                               skid_valid;
  logic signed [bsdf_pkg::DIST_W-1:0] skid_data;
  logic                               pop;

  assign pop = m_tvalid && m_tready;
  assign en  = !skid_valid;

  // Control: output and skid occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (in_valid) begin
      if (!m_tvalid || pop) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload: load output from skid or from the pipeline
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        m_tdata <= skid_data;
      end
    end else if (in_valid) begin
      if (!m_tvalid || pop) begin
        m_tdata <= in_data;
      end else begin
        skid_data <= in_data;
      end
    end
  end

  // Skid entry is only used behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry full while output empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_tvalid && !m_tready))
    else $error("skid entry filled without a stalled output");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && m_tready) |=> (m_tvalid && !skid_valid))
    else $error("skid entry not moved to output on transfer");

endmodule

// ===== hw/rtl/box_sdf_min_merge_core.sv =====
// Signed distance from a grid node to an axis-aligned box, merged by minimum
// with the distance already stored at the node. Depends on bsdf_pkg and the
// bsdf_front, bsdf_sqrt_pipe and bsdf_out_buf modules.
//
// Takes one node per cycle while the pipeline is not stalled and returns one
// merged distance per node, in order. Five stages form the per-axis excess, its
// square and the sum of squares, 32 stages compute the 32-bit integer square
// root one digit each, and the output register follows. All values are
// signed Q15.16; the outside length is the truncated root
// and saturates at 0x7FFFFFFF. Box registers are written through the cfg
// channel (always ready) and should only change while no node is in flight.
// When the output is held, one more result is kept in a skid entry before
// the whole pipeline stalls.
module box_sdf_min_merge_core (
  input  logic                                  clk,
  input  logic                                  rst,
  // Node stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [127:96] current_distance
  input  logic [4*bsdf_pkg::DIST_W-1:0]         s_tdata,
  // Result stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // [31:0] merged_distance
  output logic [bsdf_pkg::DIST_W-1:0]           m_tdata,
  // Box configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bsdf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bsdf_pkg::DIST_W-1:0]           cfg_data
);

  localparam int W = bsdf_pkg::DIST_W;

  logic signed [W-1:0]                center_x, center_y, center_z;
  logic        [bsdf_pkg::HALF_W-1:0] half_extent_x, half_extent_y, half_extent_z;

  logic                               en;
  logic                               front_valid;
  logic [bsdf_pkg::RAD_W-1:0]         front_sum;
  bsdf_pkg::side_t                    front_side;
  logic                               root_valid;
  logic [bsdf_pkg::ROOT_W-1:0]        root;
  bsdf_pkg::side_t                    root_side;
  logic signed [W-1:0]                box_dist;
  logic signed [W-1:0]                merged_distance;

  assign cfg_ready = 1'b1;
  assign s_tready  = en;

  // Box registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      center_z      <= '0;
      half_extent_x <= '0;
      half_extent_y <= '0;
      half_extent_z <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bsdf_pkg::REG_CENTER_X: center_x      <= $signed(cfg_data);
        bsdf_pkg::REG_CENTER_Y: center_y      <= $signed(cfg_data);
        bsdf_pkg::REG_CENTER_Z: center_z      <= $signed(cfg_data);
        bsdf_pkg::REG_HALF_X:   half_extent_x <= cfg_data[bsdf_pkg::HALF_W-1:0];
        bsdf_pkg::REG_HALF_Y:   half_extent_y <= cfg_data[bsdf_pkg::HALF_W-1:0];
        bsdf_pkg::REG_HALF_Z:   half_extent_z <= cfg_data[bsdf_pkg::HALF_W-1:0];
        default: ;
      endcase
    end
  end

  bsdf_front u_front (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .in_valid         (s_tvalid),
    .pos_x            ($signed(s_tdata[W-1:0])),
    .pos_y            ($signed(s_tdata[2*W-1:W])),
    .pos_z            ($signed(s_tdata[3*W-1:2*W])),
    .current_distance ($signed(s_tdata[4*W-1:3*W])),
    .center_x         (center_x),
    .center_y         (center_y),
    .center_z         (center_z),
    .half_extent_x    (half_extent_x),
    .half_extent_y    (half_extent_y),
    .half_extent_z    (half_extent_z),
    .out_valid        (front_valid),
    .out_sum          (front_sum),
    .out_side         (front_side)
  );

  bsdf_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_rad    (front_sum),
    .in_side   (front_side),
    .out_valid (root_valid),
    .out_root  (root),
    .out_side  (root_side)
  );

  // Pick outside length or inside excess, saturate, then take the minimum
  always_comb begin
    if (!root_side.outside) begin
      box_dist = root_side.qmax;
    end else if (root_side.too_big || root[bsdf_pkg::ROOT_W-1]) begin
      box_dist = bsdf_pkg::DIST_MAX;
    end else begin
      box_dist = $signed(root[W-1:0]);
    end
    merged_distance = (root_side.cur < box_dist) ? root_side.cur : box_dist;
  end

  bsdf_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (root_valid),
    .in_data  (merged_distance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
